// ===== sv/sldf_pkg.sv =====
// sldf_pkg: constants and types for the sync/length/sum frame deframer
// no dependencies; imported by the interfaces and all deframer modules
`timescale 1ns / 1ps

package sldf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  localparam logic [ByteW-1:0] SYNC_BYTE      = 8'hA5;
  localparam logic [ByteW-1:0] CMD_PAYLOAD_A  = 8'h03;
  localparam logic [ByteW-1:0] CMD_PAYLOAD_B  = 8'h10;
  localparam logic [ByteW-1:0] MAX_LEN_RESET  = 8'd200;

  // byte positions inside a frame
  localparam logic [PosW-1:0] POS_HUNT   = 9'd0;
  localparam logic [PosW-1:0] POS_SYNC2  = 9'd1;
  localparam logic [PosW-1:0] POS_YEAR   = 9'd2;
  localparam logic [PosW-1:0] POS_MONTH  = 9'd3;
  localparam logic [PosW-1:0] POS_DAY    = 9'd4;
  localparam logic [PosW-1:0] POS_CMD    = 9'd5;
  localparam logic [PosW-1:0] POS_LEN    = 9'd7;
  localparam logic [PosW-1:0] POS_HEADER = 9'd8;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic             item_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] version_year;
    logic [ByteW-1:0] version_month;
    logic [ByteW-1:0] version_day;
    logic             checksum_ok;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage

// ===== sv/sldf_in_if.sv =====
// sldf_in_if: valid/ready channel carrying one received byte per beat
// depends on sldf_pkg
`timescale 1ns / 1ps

interface sldf_in_if
  import sldf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sldf_out_if.sv =====
// sldf_out_if: valid/ready channel carrying one deframer result per beat
// depends on sldf_pkg
`timescale 1ns / 1ps

interface sldf_out_if
  import sldf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             item_kind;
  logic [ByteW-1:0] payload_byte;
  logic [ByteW-1:0] command;
  logic [ByteW-1:0] version_year;
  logic [ByteW-1:0] version_month;
  logic [ByteW-1:0] version_day;
  logic             checksum_ok;
  logic             last;

  modport source (
    output valid, output item_kind, output payload_byte, output command,
    output version_year, output version_month, output version_day,
    output checksum_ok, output last, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input command,
    input version_year, input version_month, input version_day,
    input checksum_ok, input last, output ready
  );
endinterface

// ===== sv/sldf_parser.sv =====
// sldf_parser: frame position tracker, running checksum, header capture
// and max_length register; depends on sldf_pkg
`timescale 1ns / 1ps

module sldf_parser
  import sldf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_data_i,
  output result_beat_t     res_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] year_q, year_d;
  logic [ByteW-1:0] month_q, month_d;
  logic [ByteW-1:0] day_q, day_d;
  logic [ByteW-1:0] max_len_q;

  logic [PosW-1:0]  end_pos;
  logic             cmd_has_payload;

  assign end_pos         = {1'b0, len_q} + POS_HEADER;
  assign cmd_has_payload = (cmd_q == CMD_PAYLOAD_A) || (cmd_q == CMD_PAYLOAD_B);

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;

    res_o.valid              = 1'b0;
    res_o.data.item_kind     = KIND_PAYLOAD;
    res_o.data.payload_byte  = '0;
    res_o.data.command       = cmd_q;
    res_o.data.version_year  = year_q;
    res_o.data.version_month = month_q;
    res_o.data.version_day   = day_q;
    res_o.data.checksum_ok   = 1'b0;
    res_o.data.last          = 1'b0;

    if (beat_i) begin
      priority if (pos_q == POS_HUNT) begin
        if (rx_byte_i == SYNC_BYTE) begin
          sum_d = rx_byte_i;
          pos_d = POS_SYNC2;
        end
      end else if (pos_q == POS_SYNC2) begin
        if (rx_byte_i != SYNC_BYTE) begin
          pos_d = POS_HUNT;
          sum_d = '0;
        end else begin
          sum_d = sum_q + rx_byte_i;
          pos_d = pos_q + 9'd1;
        end
      end else if (pos_q == POS_LEN) begin
        if (rx_byte_i > max_len_q) begin
          pos_d = POS_HUNT;
          sum_d = '0;
        end else begin
          len_d = rx_byte_i;
          sum_d = sum_q + rx_byte_i;
          pos_d = pos_q + 9'd1;
        end
      end else if (pos_q < POS_HEADER) begin
        if (pos_q == POS_YEAR)  year_d  = rx_byte_i;
        if (pos_q == POS_MONTH) month_d = rx_byte_i;
        if (pos_q == POS_DAY)   day_d   = rx_byte_i;
        if (pos_q == POS_CMD)   cmd_d   = rx_byte_i;
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 9'd1;
      end else if (pos_q >= end_pos) begin
        // checksum byte closes the frame
        res_o.valid            = 1'b1;
        res_o.data.item_kind   = KIND_FRAME_END;
        res_o.data.checksum_ok = (rx_byte_i == sum_q);
        res_o.data.last        = 1'b1;
        pos_d = POS_HUNT;
        sum_d = '0;
      end else begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 9'd1;
        if ((pos_q > POS_HEADER) && cmd_has_payload) begin
          res_o.valid             = 1'b1;
          res_o.data.payload_byte = rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_HUNT;
      sum_q     <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      year_q    <= '0;
      month_q   <= '0;
      day_q     <= '0;
      max_len_q <= MAX_LEN_RESET;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== sv/sldf_out_reg.sv =====
// sldf_out_reg: result register in front of the output channel
// depends on sldf_pkg
`timescale 1ns / 1ps

module sldf_out_reg
  import sldf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  result_beat_t res_i,
  output logic         take_o,
  output logic         valid_o,
  input  logic         ready_i,
  output result_t      data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // a new beat may enter when the register is empty or draining this cycle
  assign take_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q && !ready_i;
    if (take_o && res_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

endmodule

// ===== sv/sync_length_sum_frame_deframer_unit.sv =====
// sync_length_sum_frame_deframer_unit: top level of the frame deframer
// depends on sldf_pkg, sldf_in_if, sldf_out_if, sldf_parser, sldf_out_reg
//
//   channel   dir  payload                                     beat
//   rx_i      in   rx_byte                                     valid & ready
//   res_o     out  item_kind, payload_byte, command, version,  valid & ready
//                  checksum_ok, last
//   cfg       in   max_length                                  cfg_we_i
//
// one byte per cycle while rx_i.ready is high; a result appears on res_o in the cycle after its byte
// rx_i.ready is high while the result register is empty or being read
// a stall on res_o with a result held stops intake until that result is taken
// reset clears the frame state, max_length returns to 200
`timescale 1ns / 1ps

module sync_length_sum_frame_deframer_unit
  import sldf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  sldf_in_if.sink          rx_i,
  sldf_out_if.source       res_o,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_data_i
);

  logic         take;
  logic         beat;
  result_beat_t res_beat;
  result_t      res_data;

  assign rx_i.ready = take;
  assign beat       = rx_i.valid && take;

  sldf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .rx_byte_i  (rx_i.rx_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_beat)
  );

  sldf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_beat),
    .take_o  (take),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_data)
  );

  assign res_o.item_kind     = res_data.item_kind;
  assign res_o.payload_byte  = res_data.payload_byte;
  assign res_o.command       = res_data.command;
  assign res_o.version_year  = res_data.version_year;
  assign res_o.version_month = res_data.version_month;
  assign res_o.version_day   = res_data.version_day;
  assign res_o.checksum_ok   = res_data.checksum_ok;
  assign res_o.last          = res_data.last;

endmodule
